@@ sv/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment circle test package
// Shared widths, link struct and coordinate helper.
// ----------------------------------------------------------------------------
package scd_pkg;

	localparam int COORD_BITS = 16;
	localparam int CW         = (COORD_BITS > 16) ? 16 : COORD_BITS;
	localparam int DIST_W     = 33;
	localparam int RR_W       = 32;
	localparam int DIV_STEPS  = DIST_W;

	typedef struct packed {
		logic                 mid;
		logic [2*DIST_W-1:0]  c2;
		logic [DIST_W-1:0]    len;
		logic [DIST_W-1:0]    direct;
		logic [RR_W-1:0]      rr;
	} scd_link_t;

	typedef struct packed {
		logic [DIST_W-1:0] rem;
		logic [DIST_W-1:0] lq;
		logic [DIST_W-1:0] len;
		logic [DIST_W-1:0] direct;
		logic              mid;
		logic [RR_W-1:0]   rr;
	} scd_div_t;

	function automatic logic signed [16:0] coord(input logic [15:0] raw);
		logic [CW-1:0] low;
		low   = raw[CW-1:0];
		coord = 17'(signed'(low));
	endfunction

endpackage

@@ sv/scd_if.sv @@
// ----------------------------------------------------------------------------
// Segment circle test channels
// Query and result valid/ready channels.
// ----------------------------------------------------------------------------
interface scd_in_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic [15:0] radius;

	modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
		radius, input ready);
	modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
		radius, output ready);
endinterface

interface scd_out_if;
	logic        valid;
	logic        ready;
	logic [32:0] dist_sq;
	logic        inside_res;

	modport source (output valid, dist_sq, inside_res, input ready);
	modport sink (input valid, dist_sq, inside_res, output ready);
endinterface

@@ sv/scd_front.sv @@
// ----------------------------------------------------------------------------
// Segment circle test front end
// Four stages: differences, products, sums and case select, cross square.
// ----------------------------------------------------------------------------
module scd_front (
	input  logic              clk,
	input  logic              arst_n,
	scd_in_if.sink            query,
	output logic              link_valid,
	input  logic              link_ready,
	output scd_pkg::scd_link_t link
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [16:0] vx_s1, vy_s1, wx_s1, wy_s1, ux_s1, uy_s1;
	logic [15:0]        r_s1;

	logic signed [33:0] vw_x_s2, vw_y_s2, vv_x_s2, vv_y_s2;
	logic signed [33:0] cr_a_s2, cr_b_s2, ww_x_s2, ww_y_s2, uu_x_s2, uu_y_s2;
	logic [31:0]        rr_s2;

	logic               near_s3, far_s3;
	logic signed [34:0] cross_s3;
	logic [32:0]        len_s3, ww_s3, uu_s3;
	logic [31:0]        rr_s3;

	logic signed [34:0] dot_c;
	logic [33:0]        len_c;
	logic [33:0]        cmag_c;

	assign en4 = !v_s4 || link_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign query.ready = en1;
	assign link_valid  = v_s4;

	assign dot_c  = 35'(vw_x_s2) + 35'(vw_y_s2);
	assign len_c  = 34'(unsigned'(vv_x_s2)) + 34'(unsigned'(vv_y_s2));
	assign cmag_c = cross_s3[34] ? 34'(-cross_s3) : 34'(cross_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= query.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			vx_s1 <= scd_pkg::coord(query.end_x) - scd_pkg::coord(query.start_x);
			vy_s1 <= scd_pkg::coord(query.end_y) - scd_pkg::coord(query.start_y);
			wx_s1 <= scd_pkg::coord(query.point_x) - scd_pkg::coord(query.start_x);
			wy_s1 <= scd_pkg::coord(query.point_y) - scd_pkg::coord(query.start_y);
			ux_s1 <= scd_pkg::coord(query.point_x) - scd_pkg::coord(query.end_x);
			uy_s1 <= scd_pkg::coord(query.point_y) - scd_pkg::coord(query.end_y);
			r_s1  <= query.radius;
		end
		if (en2) begin
			vw_x_s2 <= vx_s1 * wx_s1;
			vw_y_s2 <= vy_s1 * wy_s1;
			vv_x_s2 <= vx_s1 * vx_s1;
			vv_y_s2 <= vy_s1 * vy_s1;
			cr_a_s2 <= vx_s1 * wy_s1;
			cr_b_s2 <= vy_s1 * wx_s1;
			ww_x_s2 <= wx_s1 * wx_s1;
			ww_y_s2 <= wy_s1 * wy_s1;
			uu_x_s2 <= ux_s1 * ux_s1;
			uu_y_s2 <= uy_s1 * uy_s1;
			rr_s2   <= 32'(r_s1) * 32'(r_s1);
		end
		if (en3) begin
			near_s3  <= (dot_c <= 35'sd0);
			far_s3   <= (35'(len_c) <= dot_c);
			cross_s3 <= 35'(cr_a_s2) - 35'(cr_b_s2);
			len_s3   <= len_c[32:0];
			ww_s3    <= 33'(unsigned'(ww_x_s2)) + 33'(unsigned'(ww_y_s2));
			uu_s3    <= 33'(unsigned'(uu_x_s2)) + 33'(unsigned'(uu_y_s2));
			rr_s3    <= rr_s2;
		end
		if (en4) begin
			link.mid    <= !near_s3 && !far_s3;
			link.c2     <= 66'(cmag_c[32:0]) * 66'(cmag_c[32:0]);
			link.len    <= len_s3;
			link.direct <= near_s3 ? ww_s3 : uu_s3;
			link.rr     <= rr_s3;
		end
	end

endmodule

@@ sv/scd_div.sv @@
// ----------------------------------------------------------------------------
// Segment circle test divider
// Restoring divide, one quotient bit per stage, then the radius compare.
// ----------------------------------------------------------------------------
module scd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               link_valid,
	output logic               link_ready,
	input  scd_pkg::scd_link_t link,
	scd_out_if.source          result
);

	localparam int N = scd_pkg::DIV_STEPS;
	localparam int W = scd_pkg::DIST_W;

	logic              v_s [N];
	logic              en  [N+1];
	scd_pkg::scd_div_t d_s [N];
	scd_pkg::scd_div_t d_in [N];
	scd_pkg::scd_div_t nxt [N];
	logic              v_out_q;
	logic              v_in [N];

	always_comb begin
		en[N] = !v_out_q || result.ready;
		for (int k = N - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign link_ready   = en[0];
	assign result.valid = v_out_q;

	always_comb begin
		logic [W:0] t;
		logic       ge;
		d_in[0].rem    = link.c2[2*W-1:W];
		d_in[0].lq     = link.c2[W-1:0];
		d_in[0].len    = link.len;
		d_in[0].direct = link.direct;
		d_in[0].mid    = link.mid;
		d_in[0].rr     = link.rr;
		v_in[0]        = link_valid;
		for (int k = 1; k < N; k++) begin
			d_in[k] = d_s[k-1];
			v_in[k] = v_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			t  = {d_in[k].rem, d_in[k].lq[W-1]};
			ge = (t >= {1'b0, d_in[k].len});
			nxt[k]     = d_in[k];
			nxt[k].rem = ge ? W'(t - {1'b0, d_in[k].len}) : t[W-1:0];
			nxt[k].lq  = {d_in[k].lq[W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) v_s[k] <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			for (int k = 0; k < N; k++) begin
				if (en[k]) v_s[k] <= v_in[k];
			end
			if (en[N]) v_out_q <= v_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [W-1:0] dist_val;
		for (int k = 0; k < N; k++) begin
			if (en[k]) d_s[k] <= nxt[k];
		end
		if (en[N]) begin
			dist_val = d_s[N-1].mid ? d_s[N-1].lq : d_s[N-1].direct;
			result.dist_sq    <= dist_val;
			result.inside_res <= (dist_val < W'(d_s[N-1].rr));
		end
	end

endmodule

@@ sv/segment_circle_test_core.sv @@
// ----------------------------------------------------------------------------
// Segment circle test core
// Squared distance from a point to a segment and a strict radius test.
//
//   channel  role  fields
//   query    sink  point_x point_y start_x start_y end_x end_y radius
//   result   src   dist_sq inside_res
//
// One query enters per cycle while the pipeline is not stalled; each result
// passes 38 registers after its query's transfer: four arithmetic stages, 33
// divider stages (one quotient bit each) and the output register. Reset
// clears the valid bits only. Each stage holds while the next one is full
// and stalled, so bubbles close up.
// ----------------------------------------------------------------------------
module segment_circle_test_core (
	input  logic       clk,
	input  logic       arst_n,
	scd_in_if.sink     query,
	scd_out_if.source  result
);

	logic               link_valid;
	logic               link_ready;
	scd_pkg::scd_link_t link;

	scd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.query      (query),
		.link_valid (link_valid),
		.link_ready (link_ready),
		.link       (link)
	);

	scd_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.link_valid (link_valid),
		.link_ready (link_ready),
		.link       (link),
		.result     (result)
	);

`ifndef SYNTHESIS
	a_mid_len: assert property (@(posedge clk) disable iff (!arst_n)
		link_valid && link.mid |-> link.len != '0)
		else $error("interior case with zero segment length");

	a_quot_fit: assert property (@(posedge clk) disable iff (!arst_n)
		link_valid && link.mid |-> link.c2[65:33] < link.len)
		else $error("quotient exceeds distance width");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> result.valid && !result.ready)
		else $error("query held off without a stalled result");
`endif

endmodule
